// ----- src/hcm_pkg.sv -----
package hcm_pkg;

    // Sample width, fixed by the payload format
    localparam int SAMPLE_BITS = 16;
    localparam int MIN_BITS    = 16;
    localparam int INV_BITS    = 24;

    // Difference sample - min_value, one guard bit
    localparam int DIFF_BITS = ((SAMPLE_BITS > MIN_BITS) ? SAMPLE_BITS : MIN_BITS) + 1;
    // Signed product of difference and Q8.16 reciprocal
    localparam int PROD_BITS = DIFF_BITS + INV_BITS + 1;
    // Normalized value in Q14, range -1..+1
    localparam int NORM_BITS = 16;

    localparam int Q_ONE   = 16384;
    localparam int THIRD_Q = 5407;

    // Ramp numerators and scaled numerators (num * 255)
    localparam int NUM_BITS = 14;
    localparam int X_BITS   = NUM_BITS + 8;

    // Exact reciprocals: floor(x / d) = (x * ceil(2^K / d)) >> K for x < 2^X_BITS
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_BITS  = 23;
    localparam logic [RECIP_BITS-1:0] RECIP_MID  = 23'd6354677; // d = 2*THIRD_Q
    localparam logic [RECIP_BITS-1:0] RECIP_EDGE = 23'd6260315; // d = Q_ONE - THIRD_Q
    localparam int RPROD_BITS = X_BITS + RECIP_BITS;

    // Register file
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;
    localparam logic REG_MIN_VALUE    = 1'b0;
    localparam logic REG_INVERSE_SPAN = 1'b1;

    typedef struct packed {
        logic signed [MIN_BITS-1:0] min_value;
        logic        [INV_BITS-1:0] inverse_span;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic       frame_end;
    } out_item_t;

endpackage

// ----- src/heatmap_color_mapper_top.sv -----
// Heatmap color mapper: one signed sample in, one jet-scale RGB pixel out.
// Input channel s_valid/s_ready/s_payload carries sample and last_pixel;
// result channel m_valid/m_ready/m_payload carries red, green, blue levels
// and frame_end, a copy of last_pixel.
// Two APB registers: min_value at 0x0 and inverse_span (Q8.16 of
// 2/(max-min)) at 0x4. Write them only while no request is in flight.
// Five register stages: subtract, multiply by the reciprocal span,
// floor/saturate, ramp numerators, reciprocal divide; m_valid is the
// valid of the last stage, the output register.
// Throughput is one pixel per cycle while m_ready is not held low; the stage
// count sets the latency, and the three constant-reciprocal multiplies sit in the last stage.
// Reset (aresetn low, synchronous) empties the pipeline and restores
// min_value = 0, inverse_span = 2.
// When the receiver holds m_ready low the result stays in the output
// register; earlier stages keep accepting until every stage holds a
// request, and only then s_ready drops. Nothing is dropped or repeated.
module heatmap_color_mapper_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  hcm_pkg::in_item_t              s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output hcm_pkg::out_item_t             m_payload,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [hcm_pkg::DATA_BITS-1:0]  pwdata,
    output logic [hcm_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    hcm_pkg::cfg_t                         cfg;
    logic                                  norm_valid;
    logic                                  norm_ready;
    logic signed [hcm_pkg::NORM_BITS-1:0]  norm_value;
    logic                                  norm_last;

    hcm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hcm_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_payload),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_norm  (norm_value),
        .out_last  (norm_last)
    );

    hcm_ramp u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_norm   (norm_value),
        .in_last   (norm_last),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_payload)
    );

endmodule

// ----- src/hcm_regs.sv -----
module hcm_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [hcm_pkg::DATA_BITS-1:0]  pwdata,
    output logic [hcm_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output hcm_pkg::cfg_t                  cfg
);

    hcm_pkg::cfg_t cfg_reg, cfg_next;
    logic          wr_en;
    logic          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                hcm_pkg::REG_MIN_VALUE:    cfg_next.min_value =
                    pwdata[hcm_pkg::MIN_BITS-1:0];
                hcm_pkg::REG_INVERSE_SPAN: cfg_next.inverse_span =
                    pwdata[hcm_pkg::INV_BITS-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_value    <= '0;
            cfg_reg.inverse_span <= hcm_pkg::INV_BITS'(2);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb begin
        case (reg_sel)
            hcm_pkg::REG_MIN_VALUE:    prdata =
                hcm_pkg::DATA_BITS'(cfg_reg.min_value);
            hcm_pkg::REG_INVERSE_SPAN: prdata =
                hcm_pkg::DATA_BITS'(cfg_reg.inverse_span);
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/hcm_norm.sv -----
module hcm_norm (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  hcm_pkg::cfg_t                         cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  hcm_pkg::in_item_t                     in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [hcm_pkg::NORM_BITS-1:0]  out_norm,
    output logic                                  out_last
);

    localparam int DW = hcm_pkg::DIFF_BITS;
    localparam int PW = hcm_pkg::PROD_BITS;
    localparam int VW = hcm_pkg::NORM_BITS;
    localparam logic signed [PW-1:0] POS_ONE = PW'(hcm_pkg::Q_ONE);
    localparam logic signed [PW-1:0] NEG_ONE = -PW'(hcm_pkg::Q_ONE);

    // Stage valids and per-stage ready (bubbles collapse)
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    logic signed [DW-1:0] diff_reg, diff_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [VW-1:0] norm_reg, norm_next;
    logic                 s1_last_reg, s2_last_reg, s3_last_reg;
    logic signed [PW-1:0] shifted;
    logic signed [PW-1:0] biased;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: subtract cold end
    assign diff_next = DW'(in_item.sample) - DW'(cfg.min_value);

    // Stage 2: scale by reciprocal span (Q16 result)
    assign prod_next = PW'(diff_reg) * PW'($signed({1'b0, cfg.inverse_span}));

    // Stage 3: floor to Q14, remove offset, saturate to [-1, 1]
    assign shifted = prod_reg >>> 2;
    assign biased  = shifted - POS_ONE;
    always_comb begin
        if (biased > POS_ONE) begin
            norm_next = VW'(POS_ONE);
        end else if (biased < NEG_ONE) begin
            norm_next = VW'(NEG_ONE);
        end else begin
            norm_next = VW'(biased);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            diff_reg    <= diff_next;
            s1_last_reg <= in_item.last_pixel;
        end
        if (s2_ready) begin
            prod_reg    <= prod_next;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_ready) begin
            norm_reg    <= norm_next;
            s3_last_reg <= s2_last_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_norm  = norm_reg;
    assign out_last  = s3_last_reg;

    // Saturated value always within [-1, 1]
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (norm_reg <= VW'(POS_ONE)) && (norm_reg >= VW'(NEG_ONE)))
        else $error("normalized value out of range");

    // A stalled product stage keeps its item
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !s3_ready) |=> (s2_valid_reg && $stable(prod_reg)))
        else $error("product stage lost an item under stall");

endmodule

// ----- src/hcm_ramp.sv -----
module hcm_ramp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [hcm_pkg::NORM_BITS-1:0]  in_norm,
    input  logic                                  in_last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output hcm_pkg::out_item_t                    out_item
);

    localparam int VW  = hcm_pkg::NORM_BITS;
    localparam int EW  = VW + 1;
    localparam int NW  = hcm_pkg::NUM_BITS;
    localparam int XW  = hcm_pkg::X_BITS;
    localparam int RW  = hcm_pkg::RPROD_BITS;
    localparam int K   = hcm_pkg::RECIP_SHIFT;
    localparam logic signed [EW-1:0] ONE_E   = EW'(hcm_pkg::Q_ONE);
    localparam logic signed [EW-1:0] THIRD_E = EW'(hcm_pkg::THIRD_Q);

    logic s4_valid_reg, s5_valid_reg;
    logic s4_ready, s5_ready;

    // Stage 4 signals
    logic signed [EW-1:0] v_ext;
    logic                 low_next, high_next, low_reg, high_reg;
    logic [NW-1:0]        rnum, bnum, gnum;
    logic [XW-1:0]        xr_next, xb_next, xg_next, xr_reg, xb_reg, xg_reg;
    logic                 s4_last_reg;

    // Stage 5 signals
    logic [RW-1:0]        pr, pb, pg;
    logic [8:0]           qr, qb, qg;
    logic [7:0]           rr, rb, rg;
    hcm_pkg::out_item_t   out_reg, out_next;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    // Stage 4: pick segment and ramp numerators, scale by 255
    assign v_ext     = EW'(in_norm);
    assign low_next  = v_ext < -THIRD_E;
    assign high_next = v_ext >= THIRD_E;

    always_comb begin
        rnum = NW'(v_ext + THIRD_E);
        bnum = NW'(THIRD_E - v_ext);
        if (low_next) begin
            gnum = NW'(v_ext + ONE_E);
        end else begin
            gnum = NW'(ONE_E - v_ext);
        end
        if (low_next || high_next) begin
            rnum = '0;
            bnum = '0;
        end else begin
            gnum = '0;
        end
    end

    assign xr_next = {rnum, 8'd0} - XW'(rnum);
    assign xb_next = {bnum, 8'd0} - XW'(bnum);
    assign xg_next = {gnum, 8'd0} - XW'(gnum);

    // Stage 5: divide by span via exact reciprocal, clamp, merge segments
    assign pr = RW'(xr_reg) * RW'(hcm_pkg::RECIP_MID);
    assign pb = RW'(xb_reg) * RW'(hcm_pkg::RECIP_MID);
    assign pg = RW'(xg_reg) * RW'(hcm_pkg::RECIP_EDGE);
    assign qr = pr[K+8:K];
    assign qb = pb[K+8:K];
    assign qg = pg[K+8:K];
    assign rr = qr[8] ? 8'hFF : qr[7:0];
    assign rb = qb[8] ? 8'hFF : qb[7:0];
    assign rg = qg[8] ? 8'hFF : qg[7:0];

    always_comb begin
        out_next.frame_end = s4_last_reg;
        if (low_reg) begin
            out_next.red_level   = 8'd0;
            out_next.blue_level  = 8'hFF;
            out_next.green_level = rg;
        end else if (high_reg) begin
            out_next.red_level   = 8'hFF;
            out_next.blue_level  = 8'd0;
            out_next.green_level = rg;
        end else begin
            out_next.red_level   = rr;
            out_next.blue_level  = rb;
            out_next.green_level = 8'hFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (s4_ready) s4_valid_reg <= in_valid;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_ready) begin
            low_reg     <= low_next;
            high_reg    <= high_next;
            xr_reg      <= xr_next;
            xb_reg      <= xb_next;
            xg_reg      <= xg_next;
            s4_last_reg <= in_last;
        end
        if (s5_ready) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_item  = out_reg;

    // Segment flags are exclusive
    a_seg_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg |-> !(low_reg && high_reg))
        else $error("both segment flags set");

    // Every jet color has one channel at full scale
    a_full_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        s5_valid_reg |-> (out_reg.red_level == 8'hFF || out_reg.green_level == 8'hFF
                          || out_reg.blue_level == 8'hFF))
        else $error("no channel at full scale");

endmodule

// ----- bench/heatmap_color_mapper_top_tb.sv -----
`timescale 1ns / 1ps

module heatmap_color_mapper_top_tb;

    // Register addresses, 4 bytes per register
    localparam logic [hcm_pkg::ADDR_BITS-1:0] ADDR_MIN = {hcm_pkg::REG_MIN_VALUE, 2'b00};
    localparam logic [hcm_pkg::ADDR_BITS-1:0] ADDR_INV = {hcm_pkg::REG_INVERSE_SPAN, 2'b00};

    // Q14 scale points of the color map
    localparam longint ONE_Q14   = 16384;
    localparam longint THIRD_Q14 = 5407;

    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 200;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

    // One row of the directed plan: a register write or a request
    typedef struct packed {
        row_kind_e                      kind;
        logic [hcm_pkg::ADDR_BITS-1:0]  addr;
        logic [31:0]                    data;
        logic signed [15:0]             sample;
        logic                           last;
        logic                           known;
        logic [7:0]                     red;
        logic [7:0]                     green;
        logic [7:0]                     blue;
    } plan_row_t;

    localparam int PLAN_ROWS = 29;

    // Extremes, zero span, saturation on both ends and the segment borders
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sh8000,    1'b0, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sh7fff,    1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sd0,       1'b0, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         -16'sd1,      1'b1, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_WRITE, ADDR_MIN, 32'hA5A5_8000, 16'sd0,       1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_WRITE, ADDR_INV, 32'hC3FF_FFFF, 16'sd0,       1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sh7fff,    1'b0, 1'b1, 8'd255, 8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sh8000,    1'b0, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         -16'sd32767,  1'b1, 1'b1, 8'd255, 8'd0,   8'd0},
        '{ROW_WRITE, ADDR_INV, 32'hFF00_0000, 16'sd0,       1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sh7fff,    1'b0, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sd12345,   1'b1, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_WRITE, ADDR_MIN, 32'h0000_7FFF, 16'sd0,       1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_WRITE, ADDR_INV, 32'h0000_0001, 16'sd0,       1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sh8000,    1'b0, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sh7fff,    1'b1, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_WRITE, ADDR_MIN, 32'h5A5A_C000, 16'sd0,       1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_WRITE, ADDR_INV, 32'h3C00_0004, 16'sd0,       1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         -16'sd16384,  1'b0, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         -16'sd5408,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         -16'sd5407,   1'b0, 1'b1, 8'd0,   8'd255, 8'd255},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sd0,       1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sd5406,    1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sd5407,    1'b0, 1'b1, 8'd255, 8'd255, 8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sd16384,   1'b1, 1'b1, 8'd255, 8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sd16385,   1'b0, 1'b1, 8'd255, 8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         -16'sd16385,  1'b0, 1'b1, 8'd0,   8'd0,   8'd255},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         16'sd1000,    1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{ROW_ITEM,  ADDR_MIN, 32'h0,         -16'sd9000,   1'b1, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    hcm_pkg::in_item_t               s_payload = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    hcm_pkg::out_item_t              m_payload;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [hcm_pkg::ADDR_BITS-1:0]   paddr   = '0;
    logic [hcm_pkg::DATA_BITS-1:0]   pwdata  = '0;
    logic [hcm_pkg::DATA_BITS-1:0]   prdata;
    logic                            pready;

    // Register copies, kept in step with every write
    logic signed [15:0]     cfg_min = 16'sd0;
    logic [23:0]            cfg_inv = 24'd2;

    hcm_pkg::out_item_t     pixel_queue [$];
    hcm_pkg::out_item_t     want_px;
    int                     mismatches = 0;
    int                     stall_left = 0;
    int                     quiet_cycles = 0;
    bit                     jitter_on = 1'b1;

    heatmap_color_mapper_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // floor(num * 255 / span), clamped to 8 bits
    function automatic logic [7:0] ramp_level(input longint num, input longint span);
        longint level;
        level = (num * 255) / span;
        return (level > 255) ? 8'd255 : level[7:0];
    endfunction

    // Jet color of one sample under the current register copies
    function automatic hcm_pkg::out_item_t color_of(input hcm_pkg::in_item_t req);
        longint             norm;
        hcm_pkg::out_item_t px;
        norm = ((longint'($signed(req.sample)) - longint'(cfg_min)) * longint'(cfg_inv));
        norm = (norm >>> 2) - ONE_Q14;
        if (norm > ONE_Q14) norm = ONE_Q14;
        if (norm < -ONE_Q14) norm = -ONE_Q14;
        if (norm < -THIRD_Q14) begin
            px.red_level   = 8'd0;
            px.blue_level  = 8'd255;
            px.green_level = ramp_level(norm + ONE_Q14, ONE_Q14 - THIRD_Q14);
        end else if (norm < THIRD_Q14) begin
            px.red_level   = ramp_level(norm + THIRD_Q14, 2 * THIRD_Q14);
            px.blue_level  = ramp_level(THIRD_Q14 - norm, 2 * THIRD_Q14);
            px.green_level = 8'd255;
        end else begin
            px.red_level   = 8'd255;
            px.blue_level  = 8'd0;
            px.green_level = ramp_level(ONE_Q14 - norm, ONE_Q14 - THIRD_Q14);
        end
        px.frame_end = req.last_pixel;
        return px;
    endfunction

    // Samples mostly around the mapped window, some anywhere, some at the edges
    function automatic logic signed [15:0] pick_sample(input int lo, input int width);
        int s;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            s = lo - width / 8 + int'($urandom_range(0, width + width / 4));
        end else if (pick < 9) begin
            s = int'($signed(16'($urandom)));
        end else begin
            case ($urandom_range(0, 4))
                0: s = -32768;
                1: s = 32767;
                2: s = lo;
                3: s = lo - 1;
                default: s = lo + 1;
            endcase
        end
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return 16'(s);
    endfunction

    // Offer one request, optionally after a short gap, and log its pixel
    task automatic send_request(input hcm_pkg::in_item_t req, input hcm_pkg::out_item_t px);
        if (jitter_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixel_queue.push_back(px);
    endtask

    // Stop offering and wait for every pixel in flight
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge aclk);
    endtask

    // APB write: setup, then access until pready, then back to idle
    task automatic write_reg(input logic [hcm_pkg::ADDR_BITS-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MIN)
            cfg_min = data[15:0];
        else if (addr == ADDR_INV)
            cfg_inv = data[23:0];
        @(posedge aclk);
    endtask

    task automatic check_level(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stall bursts, check against the oldest pixel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_queue.size() == 0) begin
                    $display("%0t ns: unexpected pixel, expected none, got %h",
                             $time, m_payload);
                    mismatches++;
                end else begin
                    want_px = pixel_queue.pop_front();
                    check_level("red_level", int'(want_px.red_level),
                                int'(m_payload.red_level));
                    check_level("green_level", int'(want_px.green_level),
                                int'(m_payload.green_level));
                    check_level("blue_level", int'(want_px.blue_level),
                                int'(m_payload.blue_level));
                    check_level("frame_end", int'(want_px.frame_end),
                                int'(m_payload.frame_end));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (jitter_on && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles where neither channel moves a request
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        hcm_pkg::in_item_t  req;
        hcm_pkg::out_item_t px;
        logic signed [15:0] lo16;
        logic [23:0]        inv24;
        logic [31:0]        junk;
        int                 width;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plan
        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (plan[i].kind == ROW_WRITE) begin
                drain_pipeline();
                write_reg(plan[i].addr, plan[i].data);
            end else begin
                req.sample     = plan[i].sample;
                req.last_pixel = plan[i].last;
                if (plan[i].known)
                    px = '{plan[i].red, plan[i].green, plan[i].blue, plan[i].last};
                else
                    px = color_of(req);
                send_request(req, px);
            end
        end

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    lo16  = -16'sd32768;
                    inv24 = 24'd2;
                    width = 65535;
                end
                1: begin
                    lo16  = 16'sd32767;
                    inv24 = 24'hFFFFFF;
                    width = 65535;
                end
                2: begin
                    lo16  = -16'sd32768;
                    inv24 = 24'd0;
                    width = 65535;
                end
                default: begin
                    lo16  = 16'($urandom);
                    width = $urandom_range(0, 1) ? $urandom_range(1, 255)
                                                 : $urandom_range(256, 65535);
                    inv24 = 24'(131072 / width + $urandom_range(0, 2));
                end
            endcase
            // no gaps or stalls in the closing phase
            if (phase == PHASES - 1) jitter_on = 1'b0;
            drain_pipeline();
            junk = $urandom;
            write_reg(ADDR_MIN, {junk[31:16], lo16});
            write_reg(ADDR_INV, {junk[7:0], inv24});
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                req.sample     = pick_sample(int'(lo16), width);
                req.last_pixel = ($urandom_range(0, 15) == 0);
                send_request(req, color_of(req));
            end
        end

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/hcm_pkg.sv
src/hcm_regs.sv
src/hcm_norm.sv
src/hcm_ramp.sv
src/heatmap_color_mapper_top.sv
bench/heatmap_color_mapper_top_tb.sv
